// File: design/positional_list_table_top_defines.svh
// ---------------------------------------------------------------------------
// positional_list_table_top_defines
// assertion macros used by the checker file plk_checker
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_TABLE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_TABLE_TOP_DEFINES_SVH

// same-cycle implication, reset masked
`define PLK_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset masked
`define PLK_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/plk_pkg.sv
// ---------------------------------------------------------------------------
// plk_pkg
// shared codes, widths and control types of the positional list table
// ---------------------------------------------------------------------------
package plk_pkg;

	localparam int IN_TDATA_W  = 40;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 48;
	localparam int OUT_TUSER_W = 2;

	localparam logic [1:0] CMD_INSERT = 2'd0;
	localparam logic [1:0] CMD_DELETE = 2'd1;
	localparam logic [1:0] CMD_READ   = 2'd2;
	localparam logic [1:0] CMD_FIND   = 2'd3;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic ins;
		logic del;
		logic sel_pos;
		logic find;
	} plk_ctrl_t;

endpackage

// File: design/plk_cell.sv
// ---------------------------------------------------------------------------
// plk_cell
// one list entry: shifts with its neighbors and flags a position or value hit
// ---------------------------------------------------------------------------
module plk_cell
	import plk_pkg::*;
#(
	parameter int INDEX = 0,
	parameter int IW    = 7,
	parameter int CW    = 8,
	parameter int VW    = 32
) (
	input  logic          clk,
	input  plk_ctrl_t     ctrl,
	input  logic [IW-1:0] k,
	input  logic [CW-1:0] count,
	input  logic [VW-1:0] key,
	input  logic [VW-1:0] left,
	input  logic [VW-1:0] right,
	output logic [VW-1:0] entry_q,
	output logic          hit
);

	localparam logic [IW-1:0] MY_IDX = IW'(INDEX);
	localparam logic [CW-1:0] MY_CNT = CW'(INDEX);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX > k) begin
				entry_q <= left;
			end else if (MY_IDX == k) begin
				entry_q <= key;
			end
		end else if (ctrl.del) begin
			if (MY_IDX >= k) begin
				entry_q <= right;
			end
		end
	end

	assign hit = (ctrl.sel_pos && (MY_IDX == k)) ||
		(ctrl.find && (MY_CNT < count) && (entry_q == key));

endmodule

// File: design/plk_pick.sv
// ---------------------------------------------------------------------------
// plk_pick
// selects the lowest hit cell and returns its index and entry
// ---------------------------------------------------------------------------
module plk_pick
	import plk_pkg::*;
#(
	parameter int CAPACITY = 128,
	parameter int IW       = 7,
	parameter int VW       = 32
) (
	input  logic [CAPACITY-1:0] hit,
	input  logic [VW-1:0]       data [CAPACITY],
	output logic                any,
	output logic [IW-1:0]       idx,
	output logic [VW-1:0]       sel
);

	logic [CAPACITY-1:0] first;

	assign first = hit & (~hit + CAPACITY'(1));
	assign any   = |hit;

	always_comb begin
		idx = '0;
		sel = '0;
		for (int j = 0; j < CAPACITY; j++) begin
			if (first[j]) begin
				idx = idx | IW'(j);
				sel = sel | data[j];
			end
		end
	end

endmodule

// File: design/positional_list_table_top.sv
// ---------------------------------------------------------------------------
// positional_list_table_top
// ordered list of signed words held in a row of shifting cells
// ---------------------------------------------------------------------------
// channel   dir  group   contents
// request   in   s_axis  tuser: command; tdata: position, value
// result    out  m_axis  tuser: status; tdata: item_value, found_position, list_length
//
// each request is accepted into the command stage; then all cells compare
// and shift together and the result is registered. arst_n clears the
// length and the valid flags; entries hold garbage until written. a
// stalled result holds the command stage, and a new request is taken once
// the command stage is empty.
// ---------------------------------------------------------------------------
module positional_list_table_top
	import plk_pkg::*;
#(
	parameter int CAPACITY    = 128,
	parameter int VALUE_WIDTH = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	// position[7:0], value[39:8]
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
	// command[1:0]
	input  logic [IN_TUSER_W-1:0]  s_axis_tuser,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// item_value[31:0], found_position[39:32], list_length[47:40]
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,
	// status[1:0]
	output logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = ((CW > 8) ? CW : 8) + 1;
	localparam int VW = VALUE_WIDTH;

	logic [1:0]    cmd_in;
	logic [7:0]    pos_in;
	logic [31:0]   val_in;
	logic [VW-1:0] key_in;
	logic [MW-1:0] pos_w;
	logic [MW-1:0] cnt_w;
	logic [MW-1:0] kidx_w;
	logic [1:0]    st_in;
	logic          accept;

	logic          valid_s1;
	logic [1:0]    cmd_s1;
	logic [1:0]    st_s1;
	logic [IW-1:0] k_s1;
	logic [VW-1:0] key_s1;

	logic [CW-1:0] count_q;
	logic [CW-1:0] count_next;
	logic          go;
	plk_ctrl_t     ctrl;

	logic [VW-1:0]       ent [CAPACITY];
	logic [CAPACITY-1:0] hit;
	logic                pick_any;
	logic [IW-1:0]       pick_idx;
	logic [VW-1:0]       pick_val;
	logic [31:0]         item32;
	logic [MW-1:0]       found_w;
	logic [MW-1:0]       len_w;

	logic          out_valid_q;
	logic [1:0]    out_st_q;
	logic [31:0]   out_item_q;
	logic [7:0]    out_found_q;
	logic [7:0]    out_len_q;

	assign cmd_in = s_axis_tuser[1:0];
	assign pos_in = s_axis_tdata[7:0];
	assign val_in = s_axis_tdata[39:8];

	generate
		if (VW <= 32) begin : g_key_trunc
			assign key_in = val_in[VW-1:0];
		end else begin : g_key_ext
			assign key_in = {{(VW-32){val_in[31]}}, val_in};
		end
	endgenerate

	assign pos_w  = MW'(pos_in);
	assign cnt_w  = MW'(count_q);
	assign kidx_w = pos_w - MW'(1);

	always_comb begin
		st_in = ST_OK;
		case (cmd_in)
			CMD_INSERT: begin
				if (count_q == CW'(CAPACITY)) begin
					st_in = ST_FULL;
				end else if (pos_in == 8'd0 || pos_w > cnt_w + MW'(1)) begin
					st_in = ST_RANGE;
				end
			end
			CMD_DELETE, CMD_READ: begin
				if (pos_in == 8'd0 || pos_w > cnt_w) begin
					st_in = ST_RANGE;
				end
			end
			default: begin
				st_in = ST_OK;
			end
		endcase
	end

	assign s_axis_tready = !valid_s1;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign go            = valid_s1 && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd_in;
			st_s1  <= st_in;
			k_s1   <= kidx_w[IW-1:0];
			key_s1 <= key_in;
		end
	end

	always_comb begin
		ctrl.ins     = go && (cmd_s1 == CMD_INSERT) && (st_s1 == ST_OK);
		ctrl.del     = go && (cmd_s1 == CMD_DELETE) && (st_s1 == ST_OK);
		ctrl.sel_pos = valid_s1 && ((cmd_s1 == CMD_DELETE) || (cmd_s1 == CMD_READ)) &&
			(st_s1 == ST_OK);
		ctrl.find    = valid_s1 && (cmd_s1 == CMD_FIND);
	end

	generate
		for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
			logic [VW-1:0] left;
			logic [VW-1:0] right;
			if (j == 0) begin : g_first
				assign left = key_s1;
			end else begin : g_mid_l
				assign left = ent[j-1];
			end
			if (j == CAPACITY - 1) begin : g_last
				assign right = ent[j];
			end else begin : g_mid_r
				assign right = ent[j+1];
			end
			plk_cell #(
				.INDEX (j),
				.IW    (IW),
				.CW    (CW),
				.VW    (VW)
			) u_cell (
				.clk     (clk),
				.ctrl    (ctrl),
				.k       (k_s1),
				.count   (count_q),
				.key     (key_s1),
				.left    (left),
				.right   (right),
				.entry_q (ent[j]),
				.hit     (hit[j])
			);
		end
	endgenerate

	plk_pick #(
		.CAPACITY (CAPACITY),
		.IW       (IW),
		.VW       (VW)
	) u_pick (
		.hit  (hit),
		.data (ent),
		.any  (pick_any),
		.idx  (pick_idx),
		.sel  (pick_val)
	);

	generate
		if (VW >= 32) begin : g_out_trunc
			assign item32 = pick_val[31:0];
		end else begin : g_out_ext
			assign item32 = {{(32-VW){pick_val[VW-1]}}, pick_val};
		end
	endgenerate

	always_comb begin
		count_next = count_q;
		if (ctrl.ins) begin
			count_next = count_q + CW'(1);
		end else if (ctrl.del) begin
			count_next = count_q - CW'(1);
		end
	end

	assign found_w = MW'(pick_idx) + MW'(1);
	assign len_w   = MW'(count_next);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (go) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_st_q    <= st_s1;
			out_item_q  <= ctrl.sel_pos ? item32 : 32'd0;
			out_found_q <= (ctrl.find && pick_any) ? found_w[7:0] : 8'd0;
			out_len_q   <= len_w[7:0];
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_st_q;
	assign m_axis_tdata  = {out_len_q, out_found_q, out_item_q};

endmodule

// File: design/plk_checker.sv
// ---------------------------------------------------------------------------
// plk_checker
// port-level checks of the positional list table, bound to the top level
// ---------------------------------------------------------------------------
`include "positional_list_table_top_defines.svh"

module plk_checker
	import plk_pkg::*;
#(
	parameter int CAPACITY = 128
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_axis_tvalid,
	input logic                   s_axis_tready,
	input logic                   m_axis_tvalid,
	input logic                   m_axis_tready,
	input logic [OUT_TDATA_W-1:0] m_axis_tdata,
	input logic [OUT_TUSER_W-1:0] m_axis_tuser
);

	`PLK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	`PLK_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request taken while command stage busy")

	`PLK_ASSERT_NOW(a_found_clean, m_axis_tvalid && (m_axis_tdata[39:32] != 8'd0), (m_axis_tuser == ST_OK) && (m_axis_tdata[31:0] == 32'd0), "find result carries status or item")

	`PLK_ASSERT_NOW(a_len_bound, m_axis_tvalid, (CAPACITY > 255) || (m_axis_tdata[47:40] <= CAPACITY), "length beyond capacity")

endmodule

bind positional_list_table_top plk_checker #(.CAPACITY(CAPACITY)) u_plk_checker (.*);
